[rtl/ule_pkg.sv]
package ule_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;

  localparam logic [2:0] OP_CLEAR        = 3'd0;
  localparam logic [2:0] OP_APPEND       = 3'd1;
  localparam logic [2:0] OP_LOOKUP       = 3'd2;
  localparam logic [2:0] OP_DELETE       = 3'd3;
  localparam logic [2:0] OP_RESET_CURSOR = 3'd4;
  localparam logic [2:0] OP_NEXT         = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     full_res;
    logic [1:0]               status;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic fetch;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic next_ok;
    logic scan_done;
    logic hit;
    logic is_delete;
    logic shift_done;
  } dp_sts_t;

endpackage

[rtl/unsorted_list_engine_unit.sv]
// Channel   Ports                 Handshake
// --------  --------------------  ------------------------------------------
// request   in_req, start, busy   taken at a rising edge with start & !busy
// result    out_res, out_valid    one-cycle strobe, receiver cannot stall
//
// Every request gives one result, strobed the cycle after the request ends.
// Clear, append, reset cursor, unused opcodes and a next past the end finish
// at the accepting edge (busy stays low); a next that reads goes on to a fetch.
// Lookup and delete scan entries from 0 up, stopping at the first match or
// past the last entry; a delete hit then moves later entries down by one.
// Scan and shift read one entry per cycle; reset empties list, rewinds cursor.
module unsorted_list_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ule_pkg::in_req_t  in_req,
  output logic              out_valid,
  output ule_pkg::out_res_t out_res
);

  ule_pkg::ctl_cmd_t cmd;
  ule_pkg::dp_sts_t  sts;

  // sequence the scan, shift and fetch phases
  ule_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_req.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold the entry store, count, cursor and result registers
  ule_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule

[rtl/ule_ctrl.sv]
module ule_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  ule_pkg::dp_sts_t  sts,
  output ule_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (opcode == ule_pkg::OP_LOOKUP || opcode == ule_pkg::OP_DELETE) begin
            state_nxt = S_SCAN;
          end else if (opcode == ule_pkg::OP_NEXT && sts.next_ok) begin
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.hit && sts.is_delete) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_FETCH: begin
        cmd.fetch     = 1'b1;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/ule_dp.sv]
module ule_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ule_pkg::in_req_t  in_req,
  input  ule_pkg::ctl_cmd_t cmd,
  output ule_pkg::dp_sts_t  sts,
  output ule_pkg::out_res_t out_res
);

  localparam int IW = ule_pkg::IDX_W;
  localparam int CW = ule_pkg::CNT_W;
  localparam int DW = ule_pkg::DATA_W;

  logic [DW-1:0] mem [ule_pkg::CAPACITY];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rvld_r, rvld_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [DW-1:0] value_r, value_nxt;
  logic [DW-1:0] rd_data_r;
  logic          found_r, found_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic          more;
  logic          hit;
  logic          scan_done;
  logic          shift_done;

  assign more       = (ptr_r < count_r);
  assign hit        = rvld_r && (rd_data_r == value_r);
  assign scan_done  = hit || (!rvld_r && !more);
  assign shift_done = !rvld_r && !more;

  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    ptr_nxt    = ptr_r;
    rvld_nxt   = 1'b0;
    ridx_nxt   = ridx_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    found_nxt  = found_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_addr    = ptr_r[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_r[IW-1:0];
    wr_data    = in_req.value;

    if (cmd.accept) begin
      op_nxt     = in_req.opcode;
      value_nxt  = in_req.value;
      found_nxt  = 1'b0;
      data_nxt   = in_req.value;
      status_nxt = ule_pkg::ST_OK;
      ptr_nxt    = '0;
      unique case (in_req.opcode)
        ule_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        ule_pkg::OP_APPEND: begin
          if (count_r >= CW'(ule_pkg::CAPACITY)) begin
            status_nxt = ule_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ule_pkg::OP_RESET_CURSOR: begin
          cursor_nxt = '0;
        end
        ule_pkg::OP_NEXT: begin
          if (cursor_r < count_r) begin
            rd_en   = 1'b1;
            rd_addr = cursor_r[IW-1:0];
          end else begin
            status_nxt = ule_pkg::ST_PAST_END;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan) begin
      // issue the next read while the previous entry is compared
      if (more && !hit) begin
        rd_en    = 1'b1;
        rvld_nxt = 1'b1;
        ridx_nxt = ptr_r[IW-1:0];
        ptr_nxt  = ptr_r + 1'b1;
      end
      if (hit) begin
        found_nxt = 1'b1;
        data_nxt  = rd_data_r;
        ptr_nxt   = CW'(ridx_r) + 1'b1;
      end
    end

    if (cmd.shift) begin
      // read entry k, then write it to k-1 in the following cycle
      if (more) begin
        rd_en    = 1'b1;
        rvld_nxt = 1'b1;
        ridx_nxt = ptr_r[IW-1:0];
        ptr_nxt  = ptr_r + 1'b1;
      end
      if (rvld_r) begin
        wr_en   = 1'b1;
        wr_addr = ridx_r - 1'b1;
        wr_data = rd_data_r;
      end
      if (shift_done) begin
        count_nxt = count_r - 1'b1;
      end
    end

    if (cmd.fetch) begin
      data_nxt   = rd_data_r;
      cursor_nxt = cursor_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      rvld_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      rvld_r   <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    ridx_r   <= ridx_nxt;
    op_r     <= op_nxt;
    value_r  <= value_nxt;
    found_r  <= found_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign sts.next_ok    = (cursor_r < count_r);
  assign sts.scan_done  = scan_done;
  assign sts.hit        = hit;
  assign sts.is_delete  = (op_r == ule_pkg::OP_DELETE);
  assign sts.shift_done = shift_done;

  assign out_res.found    = found_r;
  assign out_res.data     = data_r;
  assign out_res.count    = ule_pkg::COUNT_W'(count_r);
  assign out_res.full_res = (count_r == CW'(ule_pkg::CAPACITY));
  assign out_res.status   = status_r;

endmodule
